// File: sv/npct_pkg.sv
// npct_pkg: shared widths, codes and types of the node phase change table
// used by npct_cell, npct_ctrl and node_phase_change_table
`timescale 1ns / 1ps

package npct_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam int OP_W = 2;
  localparam int ID_W = 48;
  localparam int PH_W = 3;
  localparam int STS_W = 4;
  localparam int LIM_W = 5;

  localparam logic [LIM_W-1:0] SCAN_MAX = LIM_W'(20);

  localparam logic [OP_W-1:0] OP_REPORT = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK = 2'd1;
  localparam logic [OP_W-1:0] OP_SCAN = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  localparam logic [STS_W-1:0] STS_UPDATED = 4'd0;
  localparam logic [STS_W-1:0] STS_UNCHANGED = 4'd1;
  localparam logic [STS_W-1:0] STS_INSERTED = 4'd2;
  localparam logic [STS_W-1:0] STS_ZERO_ID = 4'd3;
  localparam logic [STS_W-1:0] STS_FULL = 4'd4;
  localparam logic [STS_W-1:0] STS_ACKED = 4'd5;
  localparam logic [STS_W-1:0] STS_ACK_MISS = 4'd6;
  localparam logic [STS_W-1:0] STS_SCAN_ENTRY = 4'd7;
  localparam logic [STS_W-1:0] STS_SCAN_EMPTY = 4'd8;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_WALK,
    FSM_FINISH
  } fsm_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [PH_W-1:0] phase;
    logic mark;
  } entry_t;

  typedef struct packed {
    logic shift;
    entry_t tail;
  } ring_ctl_t;

  typedef struct packed {
    fsm_t state;
    logic [CNT_W-1:0] count;
    logic [LIM_W-1:0] found;
    logic [LIM_W-1:0] lim;
  } ctrl_sts_t;

endpackage

// File: sv/node_phase_change_table.sv
// node_phase_change_table: top level, a ring of npct_cell entries driven by npct_ctrl
// depends on npct_pkg, npct_cell and npct_ctrl
`timescale 1ns / 1ps

// The node table sits in a ring of TABLE_DEPTH cells that rotates one place per
// cycle while an item is at work, unless a scan entry waits on a stalled output;
// the controller edits the entry at the head as it passes to the tail, so every
// item but op code 3 walks the whole ring and leaves the table back in insertion
// order. An item is transferred in, then walks the ring, then gives its final
// result, which waits while the output side stalls a pending result.
// Op code 3 is taken without a ring walk and gives no result. scan_limit may be
// written at any cycle while the block is idle; cfg_ready is always high.

module node_phase_change_table (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [npct_pkg::OP_W-1:0]         op,
  input  logic [npct_pkg::ID_W-1:0]         node_id,
  input  logic [npct_pkg::PH_W-1:0]         phase,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [npct_pkg::LIM_W-1:0]        scan_limit,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [npct_pkg::STS_W-1:0]        status,
  output logic [npct_pkg::ID_W-1:0]         entry_id,
  output logic [npct_pkg::PH_W-1:0]         entry_phase,
  output logic                              last
);

  npct_pkg::entry_t    cell_q [npct_pkg::TABLE_DEPTH];
  npct_pkg::ring_ctl_t ring;
  npct_pkg::ctrl_sts_t sts;

  npct_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .node_id     (node_id),
    .phase       (phase),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (scan_limit),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .entry_id    (entry_id),
    .entry_phase (entry_phase),
    .last        (last),
    .head        (cell_q[0]),
    .ring        (ring),
    .sts         (sts)
  );

  for (genvar i = 0; i < npct_pkg::TABLE_DEPTH; i++) begin : g_cell
    if (i == npct_pkg::TABLE_DEPTH - 1) begin : g_tail
      npct_cell u_cell (
        .clk   (clk),
        .shift (ring.shift),
        .d     (ring.tail),
        .q     (cell_q[i])
      );
    end else begin : g_body
      npct_cell u_cell (
        .clk   (clk),
        .shift (ring.shift),
        .d     (cell_q[i+1]),
        .q     (cell_q[i])
      );
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sts.count <= npct_pkg::CNT_W'(npct_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (sts.state == npct_pkg::FSM_WALK) |-> (sts.found <= sts.lim))
    else $error("scan found more entries than its limit");

  a_accept_walk: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (op != npct_pkg::OP_NONE)) |=>
    (sts.state == npct_pkg::FSM_WALK))
    else $error("transfer in did not start a ring walk");

  a_scan_id: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == npct_pkg::STS_SCAN_ENTRY)) |-> (entry_id != '0))
    else $error("scan entry with zero node id");

endmodule

// File: sv/npct_cell.sv
// npct_cell: one table entry of the rotating cell ring
// depends on npct_pkg for the entry type
`timescale 1ns / 1ps

module npct_cell (
  input  logic            clk,
  input  logic            shift,
  input  npct_pkg::entry_t d,
  output npct_pkg::entry_t q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

// File: sv/npct_ctrl.sv
// npct_ctrl: sequencer that walks the cell ring, edits the head entry and
// holds the entry count, scan limit register and result register; uses npct_pkg
`timescale 1ns / 1ps

module npct_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [npct_pkg::OP_W-1:0]         op,
  input  logic [npct_pkg::ID_W-1:0]         node_id,
  input  logic [npct_pkg::PH_W-1:0]         phase,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [npct_pkg::LIM_W-1:0]        cfg_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [npct_pkg::STS_W-1:0]        status,
  output logic [npct_pkg::ID_W-1:0]         entry_id,
  output logic [npct_pkg::PH_W-1:0]         entry_phase,
  output logic                              last,
  input  npct_pkg::entry_t                  head,
  output npct_pkg::ring_ctl_t               ring,
  output npct_pkg::ctrl_sts_t               sts
);

  npct_pkg::fsm_t state, state_next;

  logic [npct_pkg::OP_W-1:0]  op_r;
  logic [npct_pkg::ID_W-1:0]  id_r;
  logic [npct_pkg::PH_W-1:0]  phase_r;
  logic [npct_pkg::IDX_W-1:0] step;
  logic [npct_pkg::CNT_W-1:0] count;
  logic [npct_pkg::LIM_W-1:0] lim_cfg, lim, found, lim_eff;
  logic                       hit, hit_chg, ins;
  logic                       pend_v;
  logic [npct_pkg::ID_W-1:0]  pend_id;
  logic [npct_pkg::PH_W-1:0]  pend_ph;

  logic                       accept, out_free, head_live, match, do_ins, scan_hit, step_last;
  logic                       shift, emit;
  logic [npct_pkg::STS_W-1:0] emit_status, final_status;
  logic [npct_pkg::ID_W-1:0]  emit_id;
  logic [npct_pkg::PH_W-1:0]  emit_ph;
  logic                       emit_last;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign head_live = npct_pkg::CNT_W'(step) < count;
  assign step_last = step == npct_pkg::IDX_W'(npct_pkg::TABLE_DEPTH - 1);
  assign match     = head_live && (head.id == id_r) && !hit &&
                     ((op_r == npct_pkg::OP_REPORT) || (op_r == npct_pkg::OP_ACK));
  assign do_ins    = (op_r == npct_pkg::OP_REPORT) && !hit && !ins && (id_r != '0) &&
                     (npct_pkg::CNT_W'(step) == count);
  assign scan_hit  = (op_r == npct_pkg::OP_SCAN) && head_live && head.mark && (found < lim);

  always_comb begin
    if (lim_cfg == '0) begin
      lim_eff = npct_pkg::LIM_W'(1);
    end else if (lim_cfg > npct_pkg::SCAN_MAX) begin
      lim_eff = npct_pkg::SCAN_MAX;
    end else begin
      lim_eff = lim_cfg;
    end
  end

  // head entry as it leaves for the tail
  always_comb begin
    ring.tail = head;
    if (match && (op_r == npct_pkg::OP_REPORT)) begin
      ring.tail.phase = phase_r;
      if (head.phase != phase_r) begin
        ring.tail.mark = 1'b1;
      end
    end else if (match) begin
      ring.tail.mark = 1'b0;
    end else if (do_ins) begin
      ring.tail.id    = id_r;
      ring.tail.phase = phase_r;
      ring.tail.mark  = phase_r != '0;
    end
  end
  assign ring.shift = shift;

  always_comb begin
    if (op_r == npct_pkg::OP_REPORT) begin
      if (hit) begin
        final_status = hit_chg ? npct_pkg::STS_UPDATED : npct_pkg::STS_UNCHANGED;
      end else if (id_r == '0) begin
        final_status = npct_pkg::STS_ZERO_ID;
      end else begin
        final_status = ins ? npct_pkg::STS_INSERTED : npct_pkg::STS_FULL;
      end
    end else if (op_r == npct_pkg::OP_ACK) begin
      final_status = hit ? npct_pkg::STS_ACKED : npct_pkg::STS_ACK_MISS;
    end else begin
      final_status = pend_v ? npct_pkg::STS_SCAN_ENTRY : npct_pkg::STS_SCAN_EMPTY;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      npct_pkg::FSM_IDLE: begin
        if (accept && (op != npct_pkg::OP_NONE)) begin
          state_next = npct_pkg::FSM_WALK;
        end
      end
      npct_pkg::FSM_WALK: begin
        if (shift && step_last) begin
          state_next = npct_pkg::FSM_FINISH;
        end
      end
      npct_pkg::FSM_FINISH: begin
        if (out_free) begin
          state_next = npct_pkg::FSM_IDLE;
        end
      end
      default: state_next = npct_pkg::FSM_IDLE;
    endcase
  end

  // outputs of each state
  always_comb begin
    in_stall    = 1'b1;
    shift       = 1'b0;
    emit        = 1'b0;
    emit_status = final_status;
    emit_id     = '0;
    emit_ph     = '0;
    emit_last   = 1'b1;
    unique case (state)
      npct_pkg::FSM_IDLE: begin
        in_stall = 1'b0;
      end
      npct_pkg::FSM_WALK: begin
        shift       = !(scan_hit && pend_v) || out_free;
        emit        = scan_hit && pend_v && out_free;
        emit_status = npct_pkg::STS_SCAN_ENTRY;
        emit_id     = pend_id;
        emit_ph     = pend_ph;
        emit_last   = 1'b0;
      end
      npct_pkg::FSM_FINISH: begin
        emit = out_free;
        if (pend_v && (op_r == npct_pkg::OP_SCAN)) begin
          emit_id = pend_id;
          emit_ph = pend_ph;
        end
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= npct_pkg::FSM_IDLE;
      count     <= '0;
      lim_cfg   <= npct_pkg::SCAN_MAX;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        lim_cfg <= cfg_data;
      end
      if (shift && do_ins) begin
        count <= count + 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= op;
      id_r    <= node_id;
      phase_r <= phase;
      lim     <= lim_eff;
      step    <= '0;
      hit     <= 1'b0;
      hit_chg <= 1'b0;
      ins     <= 1'b0;
      found   <= '0;
      pend_v  <= 1'b0;
    end else if (shift) begin
      step <= step + 1'b1;
      if (match) begin
        hit     <= 1'b1;
        hit_chg <= head.phase != phase_r;
      end
      if (do_ins) begin
        ins <= 1'b1;
      end
      if (scan_hit) begin
        pend_v  <= 1'b1;
        pend_id <= head.id;
        pend_ph <= head.phase;
        found   <= found + 1'b1;
      end
    end
    if (emit) begin
      status      <= emit_status;
      entry_id    <= emit_id;
      entry_phase <= emit_ph;
      last        <= emit_last;
    end
  end

  assign sts.state = state;
  assign sts.count = count;
  assign sts.found = found;
  assign sts.lim   = lim;

endmodule

// File: tb/tb.sv
// tb: self-checking bench for node_phase_change_table, with a shadow node table that
// predicts every reply, and a queue-fed driver and a monitor with random stalls
// depends on npct_pkg and node_phase_change_table
`timescale 1ns / 1ps

module tb;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = npct_pkg::TABLE_DEPTH + 16;

  typedef struct packed {
    logic [npct_pkg::OP_W-1:0] op;
    logic [npct_pkg::ID_W-1:0] id;
    logic [npct_pkg::PH_W-1:0] ph;
  } node_cmd_t;

  typedef struct packed {
    logic [npct_pkg::STS_W-1:0] status;
    logic [npct_pkg::ID_W-1:0] id;
    logic [npct_pkg::PH_W-1:0] ph;
    logic last;
  } node_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [npct_pkg::OP_W-1:0] op = npct_pkg::OP_NONE;
  logic [npct_pkg::ID_W-1:0] node_id = '0;
  logic [npct_pkg::PH_W-1:0] phase = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [npct_pkg::LIM_W-1:0] scan_limit = npct_pkg::SCAN_MAX;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [npct_pkg::STS_W-1:0] status;
  logic [npct_pkg::ID_W-1:0] entry_id;
  logic [npct_pkg::PH_W-1:0] entry_phase;
  logic last;

  logic hold_on = 1'b0;
  bit calm = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;
  int quiet_cycles = 0;
  int fail_count = 0;

  node_cmd_t node_cmds[$];
  node_reply_t table_replies[$];
  logic [npct_pkg::ID_W-1:0] known_ids[$];

  logic [npct_pkg::ID_W-1:0] shadow_id[npct_pkg::TABLE_DEPTH];
  logic [npct_pkg::PH_W-1:0] shadow_ph[npct_pkg::TABLE_DEPTH];
  logic shadow_mark[npct_pkg::TABLE_DEPTH];
  int shadow_count = 0;
  logic [npct_pkg::LIM_W-1:0] shadow_limit = npct_pkg::SCAN_MAX;

  node_phase_change_table dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .node_id(node_id),
    .phase(phase),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .scan_limit(scan_limit),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .entry_id(entry_id),
    .entry_phase(entry_phase),
    .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic apply_table_cmd(input node_cmd_t c);
    int hit;
    int k;
    int n;
    int lim;
    int last_k;
    node_reply_t r;
    hit = -1;
    for (k = 0; k < shadow_count; k++)
      if (hit < 0 && shadow_id[k] == c.id) hit = k;
    r = '0;
    r.last = 1'b1;
    case (c.op)
      npct_pkg::OP_REPORT: begin
        if (hit >= 0) begin
          if (shadow_ph[hit] != c.ph) begin
            shadow_ph[hit] = c.ph;
            shadow_mark[hit] = 1'b1;
            r.status = npct_pkg::STS_UPDATED;
          end else begin
            r.status = npct_pkg::STS_UNCHANGED;
          end
        end else if (c.id == '0) begin
          r.status = npct_pkg::STS_ZERO_ID;
        end else if (shadow_count >= npct_pkg::TABLE_DEPTH) begin
          r.status = npct_pkg::STS_FULL;
        end else begin
          shadow_id[shadow_count] = c.id;
          shadow_ph[shadow_count] = c.ph;
          shadow_mark[shadow_count] = (c.ph != '0);
          shadow_count++;
          r.status = npct_pkg::STS_INSERTED;
        end
        table_replies.push_back(r);
      end
      npct_pkg::OP_ACK: begin
        if (hit >= 0) begin
          shadow_mark[hit] = 1'b0;
          r.status = npct_pkg::STS_ACKED;
        end else begin
          r.status = npct_pkg::STS_ACK_MISS;
        end
        table_replies.push_back(r);
      end
      npct_pkg::OP_SCAN: begin
        lim = int'(shadow_limit);
        if (lim < 1) lim = 1;
        if (lim > int'(npct_pkg::SCAN_MAX)) lim = int'(npct_pkg::SCAN_MAX);
        n = 0;
        last_k = -1;
        for (k = 0; k < shadow_count; k++)
          if (shadow_mark[k] && n < lim) begin
            n++;
            last_k = k;
          end
        if (n == 0) begin
          r.status = npct_pkg::STS_SCAN_EMPTY;
          table_replies.push_back(r);
        end else begin
          for (k = 0; k <= last_k; k++)
            if (shadow_mark[k]) begin
              r.status = npct_pkg::STS_SCAN_ENTRY;
              r.id = shadow_id[k];
              r.ph = shadow_ph[k];
              r.last = (k == last_k);
              table_replies.push_back(r);
            end
        end
      end
      default: begin
      end
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    node_cmd_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_table_cmd({op, node_id, phase});
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 17);
          in_valid <= 1'b0;
        end else if (node_cmds.size() != 0) begin
          nxt = node_cmds.pop_front();
          in_valid <= 1'b1;
          op <= nxt.op;
          node_id <= nxt.id;
          phase <= nxt.ph;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    node_reply_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (table_replies.size() == 0) begin
          $error("unexpected transfer: status %0d, entry_id %h", status, entry_id);
          fail_count++;
        end else begin
          want = table_replies.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            fail_count++;
          end
          if (entry_id !== want.id) begin
            $error("entry_id: expected %h, actual %h", want.id, entry_id);
            fail_count++;
          end
          if (entry_phase !== want.ph) begin
            $error("entry_phase: expected %0d, actual %0d", want.ph, entry_phase);
            fail_count++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last);
            fail_count++;
          end
        end
      end
      if (recv_gap > 0) recv_gap--;
      else if (!calm && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 18);
      out_stall <= hold_on || (recv_gap > 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("node_phase_change_table: mismatch");
      $finish;
    end
  end

  task automatic queue_cmd(input logic [npct_pkg::OP_W-1:0] o,
                           input logic [npct_pkg::ID_W-1:0] id,
                           input logic [npct_pkg::PH_W-1:0] ph);
    node_cmd_t c;
    c.op = o;
    c.id = id;
    c.ph = ph;
    node_cmds.push_back(c);
  endtask

  task automatic queue_random(input int count, input int report_pct, input int new_pct);
    int i;
    int r;
    node_cmd_t c;
    for (i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < report_pct) c.op = npct_pkg::OP_REPORT;
      else if (r < report_pct + (100 - report_pct) / 2) c.op = npct_pkg::OP_ACK;
      else if (r < 96) c.op = npct_pkg::OP_SCAN;
      else c.op = npct_pkg::OP_NONE;
      c.ph = npct_pkg::PH_W'($urandom_range(0, 7));
      r = $urandom_range(0, 99);
      if (r < 4) begin
        c.id = '0;
      end else if (known_ids.size() == 0 || r < 4 + new_pct) begin
        c.id = npct_pkg::ID_W'({$urandom, $urandom});
        if (c.id == '0) c.id = npct_pkg::ID_W'(1);
        if (c.op == npct_pkg::OP_REPORT) known_ids.push_back(c.id);
      end else begin
        c.id = known_ids[$urandom_range(0, known_ids.size() - 1)];
      end
      node_cmds.push_back(c);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (node_cmds.size() != 0 || in_valid || table_replies.size() != 0)
      @(negedge clk);
  endtask

  task automatic program_scan_limit(input logic [npct_pkg::LIM_W-1:0] v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    scan_limit <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_limit = v;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    program_scan_limit(npct_pkg::SCAN_MAX);
    queue_cmd(npct_pkg::OP_SCAN, '0, '0);
    queue_cmd(npct_pkg::OP_ACK, '0, '0);
    queue_cmd(npct_pkg::OP_REPORT, '0, 3'd5);
    queue_cmd(npct_pkg::OP_REPORT, {npct_pkg::ID_W{1'b1}}, 3'd7);
    queue_cmd(npct_pkg::OP_REPORT, npct_pkg::ID_W'(1), 3'd0);
    queue_cmd(npct_pkg::OP_REPORT, npct_pkg::ID_W'(1), 3'd0);
    queue_cmd(npct_pkg::OP_REPORT, npct_pkg::ID_W'(1), 3'd2);
    queue_cmd(npct_pkg::OP_REPORT, {1'b1, {(npct_pkg::ID_W-1){1'b0}}}, 3'd4);
    queue_cmd(npct_pkg::OP_SCAN, '0, '0);
    queue_cmd(npct_pkg::OP_ACK, npct_pkg::ID_W'(1), 3'd7);
    queue_cmd(npct_pkg::OP_ACK, npct_pkg::ID_W'(48'h123), '0);
    queue_cmd(npct_pkg::OP_NONE, {npct_pkg::ID_W{1'b1}}, 3'd7);
    queue_cmd(npct_pkg::OP_REPORT, {npct_pkg::ID_W{1'b1}}, 3'd7);
    queue_cmd(npct_pkg::OP_REPORT, {npct_pkg::ID_W{1'b1}}, 3'd0);
    queue_cmd(npct_pkg::OP_SCAN, '0, 3'd7);
    queue_cmd(npct_pkg::OP_ACK, {npct_pkg::ID_W{1'b1}}, '0);
    queue_cmd(npct_pkg::OP_ACK, {1'b1, {(npct_pkg::ID_W-1){1'b0}}}, '0);
    queue_cmd(npct_pkg::OP_SCAN, {npct_pkg::ID_W{1'b1}}, '0);
    known_ids.push_back({npct_pkg::ID_W{1'b1}});
    known_ids.push_back(npct_pkg::ID_W'(1));
    known_ids.push_back({1'b1, {(npct_pkg::ID_W-1){1'b0}}});

    program_scan_limit(npct_pkg::LIM_W'(1));
    queue_random(30, 55, 30);

    program_scan_limit(npct_pkg::LIM_W'(0));
    queue_random(60, 90, 90);

    // receiver holds off while the sender keeps the input busy
    program_scan_limit(npct_pkg::LIM_W'(31));
    queue_random(30, 55, 30);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;

    program_scan_limit(npct_pkg::LIM_W'(3));
    queue_random(30, 50, 30);

    program_scan_limit(npct_pkg::LIM_W'(7));
    queue_random(30, 50, 30);

    program_scan_limit(npct_pkg::LIM_W'($urandom_range(1, 20)));
    calm = 1'b1;
    queue_random(25, 50, 30);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("node_phase_change_table: match");
    else
      $display("node_phase_change_table: mismatch");
    $finish;
  end

endmodule
